// ===== rtl/pab_pkg.sv =====
// Package: shared constants and types for the progressive accumulation buffer.
package pab_pkg;
   localparam int MaxWidthDefault  = 256;
   localparam int MaxHeightDefault = 256;
   localparam int MaxBlockDefault  = 16;
   localparam int SumWidth         = 32;
   localparam int ChanWidth        = 24;
   localparam int LevelWidth       = 5;
   localparam int CsrWidth         = 9;
   localparam int DivBits          = 48;

   typedef enum logic [0:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic [0:0] {
      ACT_MERGE = 1'b0,
      ACT_READ  = 1'b1
   } action_type;

   typedef struct packed {
      logic start;
      logic busy;
   } div_ctrl_type;
endpackage

// ===== rtl/pab_divider.sv =====
// Divider: three restoring quotients (sum << 16) / weight, one bit per cycle, saturated.
module pab_divider (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [pab_pkg::SumWidth-1:0]          num_r,
   input  logic [pab_pkg::SumWidth-1:0]          num_g,
   input  logic [pab_pkg::SumWidth-1:0]          num_b,
   input  logic [pab_pkg::SumWidth-1:0]          den,
   output pab_pkg::div_ctrl_type                 ctrl,
   output logic                                  done,
   output logic [pab_pkg::ChanWidth-1:0]         quo_r,
   output logic [pab_pkg::ChanWidth-1:0]         quo_g,
   output logic [pab_pkg::ChanWidth-1:0]         quo_b
);
   localparam int NB = pab_pkg::DivBits + pab_pkg::SumWidth;
   localparam int CW = $clog2(NB + 1);

   logic [NB-1:0] acc_ff [3];
   logic [NB-1:0] acc_in [3];
   logic [pab_pkg::SumWidth-1:0] den_ff;
   logic [CW-1:0] cnt_ff;
   logic busy_ff, done_ff;

   always_comb begin
      logic [pab_pkg::SumWidth:0] rem;
      for (int c = 0; c < 3; c++) begin
         rem = {acc_ff[c][NB-1 -: pab_pkg::SumWidth], acc_ff[c][pab_pkg::DivBits-1]};
         if (rem >= {1'b0, den_ff}) begin
            rem = rem - {1'b0, den_ff};
            acc_in[c] = {rem[pab_pkg::SumWidth-1:0], acc_ff[c][pab_pkg::DivBits-2:0], 1'b1};
         end else begin
            acc_in[c] = {rem[pab_pkg::SumWidth-1:0], acc_ff[c][pab_pkg::DivBits-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start && !busy_ff) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(pab_pkg::DivBits);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy_ff) begin
         den_ff    <= den;
         acc_ff[0] <= {pab_pkg::SumWidth'(0), num_r, 16'd0};
         acc_ff[1] <= {pab_pkg::SumWidth'(0), num_g, 16'd0};
         acc_ff[2] <= {pab_pkg::SumWidth'(0), num_b, 16'd0};
      end else if (busy_ff) begin
         acc_ff <= acc_in;
      end
   end

   function automatic logic [pab_pkg::ChanWidth-1:0] sat
      (input logic [pab_pkg::DivBits-1:0] q);
      return (|q[pab_pkg::DivBits-1:pab_pkg::ChanWidth]) ? '1 : q[pab_pkg::ChanWidth-1:0];
   endfunction

   assign quo_r = sat(acc_ff[0][pab_pkg::DivBits-1:0]);
   assign quo_g = sat(acc_ff[1][pab_pkg::DivBits-1:0]);
   assign quo_b = sat(acc_ff[2][pab_pkg::DivBits-1:0]);
   assign done  = done_ff;
   assign ctrl  = '{start: start, busy: busy_ff};
endmodule

// ===== rtl/progressive_accumulation_buffer_unit.sv =====
// Top level: progressive accumulation buffer with pixel memories and divider.
//  channel | ports  | direction | item
//  request | req_*  | in        | merge sample or pixel read
//  result  | rsp_*  | out       | normalised pixel, one per read
//  config  | csr_*  | in        | frame width / height writes
// After reset a clearing pass over every memory entry zeroes level and weight.
// A merge steps read, wait, write per covered pixel; outside the frame no wait, no write.
// A read uses the 48-step bit-serial divider; with zero weight it is skipped.
// One item at a time; the next is taken while a result waits in the output register.
module progressive_accumulation_buffer_unit #(
   parameter int MAX_WIDTH  = pab_pkg::MaxWidthDefault,
   parameter int MAX_HEIGHT = pab_pkg::MaxHeightDefault,
   parameter int MAX_BLOCK  = pab_pkg::MaxBlockDefault
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_action,
   input  logic [7:0]                       req_coord_x,
   input  logic [7:0]                       req_coord_y,
   input  logic [4:0]                       req_block_size,
   input  logic [pab_pkg::ChanWidth-1:0]    req_sample_red,
   input  logic [pab_pkg::ChanWidth-1:0]    req_sample_green,
   input  logic [pab_pkg::ChanWidth-1:0]    req_sample_blue,
   input  logic [pab_pkg::ChanWidth-1:0]    req_sample_weight,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [pab_pkg::ChanWidth-1:0]    rsp_pixel_red,
   output logic [pab_pkg::ChanWidth-1:0]    rsp_pixel_green,
   output logic [pab_pkg::ChanWidth-1:0]    rsp_pixel_blue,
   output logic                             rsp_pixel_valid,
   input  logic                             csr_write,
   input  logic                             csr_index,
   input  logic [pab_pkg::CsrWidth-1:0]     csr_data
);
   localparam int XW = $clog2(MAX_WIDTH);
   localparam int YW = $clog2(MAX_HEIGHT);
   localparam int AW = XW + YW;
   localparam int DEPTH = 1 << AW;
   localparam int SW = pab_pkg::SumWidth;
   localparam int LW = pab_pkg::LevelWidth;
   localparam int PW = 14;
   localparam int OW = 7;
   localparam logic [LW-1:0] LVL_FULL = LW'(1);

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_RD, ST_WAIT, ST_MOD, ST_DIV, ST_DIVWAIT, ST_OUT
   } state_type;

   logic [3*SW-1:0] col_mem [DEPTH];
   logic [SW+LW-1:0] wl_mem [DEPTH];

   state_type state_ff;
   logic [AW-1:0] clr_ff;
   logic [8:0] fw_ff, fh_ff;
   logic act_ff;
   logic [PW-1:0] bx_ff, by_ff;
   logic [OW-1:0] ox_ff, oy_ff, s_ff;
   logic [LW-1:0] lvl_ff;
   logic [pab_pkg::ChanWidth-1:0] sr_ff, sg_ff, sb_ff, sw_ff;
   logic [3*SW-1:0] col_rd_ff;
   logic [SW+LW-1:0] wl_rd_ff;
   logic rsp_valid_ff;
   logic [pab_pkg::ChanWidth-1:0] or_ff, og_ff, ob_ff;
   logic ov_ff;

   logic [PW-1:0] px, py, ew, eh;
   logic in_frame;
   logic [AW-1:0] addr;
   logic mem_rd, mem_wr;
   logic [3*SW-1:0] col_wr;
   logic [SW+LW-1:0] wl_wr;
   logic div_start, div_done;
   logic [pab_pkg::ChanWidth-1:0] qr, qg, qb;
   pab_pkg::div_ctrl_type div_ctrl;
   logic s_ok;
   logic [LW-1:0] s_lvl;

   assign ew = (PW'(fw_ff) < PW'(MAX_WIDTH)) ? PW'(fw_ff) : PW'(MAX_WIDTH);
   assign eh = (PW'(fh_ff) < PW'(MAX_HEIGHT)) ? PW'(fh_ff) : PW'(MAX_HEIGHT);
   assign px = bx_ff + PW'(ox_ff);
   assign py = by_ff + PW'(oy_ff);
   assign in_frame = (px < ew) && (py < eh);
   assign addr = {py[YW-1:0], px[XW-1:0]};

   always_comb begin
      s_ok  = 1'b0;
      s_lvl = '0;
      for (int k = 0; k < 7; k++) begin
         if (32'(req_block_size) == (32'd1 << k) && (32'd1 << k) <= 32'(MAX_BLOCK)) begin
            s_ok  = 1'b1;
            s_lvl = LW'(k + 1);
         end
      end
   end

   function automatic logic [SW-1:0] sadd(input logic [SW-1:0] a, input logic [SW-1:0] b);
      logic [SW:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[SW] ? '1 : s[SW-1:0];
   endfunction

   always_comb begin
      logic hit;
      hit = (wl_rd_ff[LW-1:0] == LVL_FULL);
      if (hit) begin
         col_wr = {sadd(col_rd_ff[3*SW-1:2*SW], SW'(sr_ff)),
                   sadd(col_rd_ff[2*SW-1:SW], SW'(sg_ff)),
                   sadd(col_rd_ff[SW-1:0], SW'(sb_ff))};
         wl_wr  = {sadd(wl_rd_ff[SW+LW-1:LW], SW'(sw_ff)), LVL_FULL};
      end else begin
         col_wr = {SW'(sr_ff), SW'(sg_ff), SW'(sb_ff)};
         wl_wr  = {SW'(sw_ff), lvl_ff};
      end
   end

   assign mem_rd = (state_ff == ST_RD) && in_frame;
   assign mem_wr = (state_ff == ST_MOD) && !act_ff && in_frame;
   assign div_start = (state_ff == ST_DIV);

   always_ff @(posedge clock) begin
      if (state_ff == ST_CLEAR) begin
         wl_mem[clr_ff] <= '0;
      end else if (mem_wr) begin
         col_mem[addr] <= col_wr;
         wl_mem[addr]  <= wl_wr;
      end
      if (mem_rd) begin
         wl_rd_ff <= wl_mem[addr];
         col_rd_ff <= col_mem[addr];
      end else if ((state_ff == ST_RD) && act_ff) begin
         wl_rd_ff <= '0;
      end
   end

   pab_divider u_div (
      .clock (clock), .reset (reset), .start (div_start),
      .num_r (col_rd_ff[3*SW-1:2*SW]), .num_g (col_rd_ff[2*SW-1:SW]),
      .num_b (col_rd_ff[SW-1:0]), .den (wl_rd_ff[SW+LW-1:LW]),
      .ctrl (div_ctrl), .done (div_done), .quo_r (qr), .quo_g (qg), .quo_b (qb)
   );

   assign req_ready = (state_ff == ST_IDLE) && !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         fw_ff        <= 9'd256;
         fh_ff        <= 9'd256;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            case (pab_pkg::csr_index_type'(csr_index))
               pab_pkg::CSR_FRAME_WIDTH:  fw_ff <= csr_data;
               pab_pkg::CSR_FRAME_HEIGHT: fh_ff <= csr_data;
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_ready && state_ff != ST_OUT) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (&clr_ff) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (req_valid) begin
                  act_ff <= req_action;
                  sr_ff <= req_sample_red;
                  sg_ff <= req_sample_green;
                  sb_ff <= req_sample_blue;
                  sw_ff <= req_sample_weight;
                  lvl_ff <= s_lvl;
                  ox_ff <= '0;
                  oy_ff <= '0;
                  if (req_action == pab_pkg::ACT_READ) begin
                     bx_ff <= PW'(req_coord_x);
                     by_ff <= PW'(req_coord_y);
                     s_ff  <= OW'(1);
                     state_ff <= ST_RD;
                  end else if (s_ok) begin
                     bx_ff <= PW'(req_coord_x) * PW'(req_block_size);
                     by_ff <= PW'(req_coord_y) * PW'(req_block_size);
                     s_ff  <= OW'(req_block_size);
                     state_ff <= ST_RD;
                  end
               end
            end
            ST_RD: begin
               if (act_ff) begin
                  state_ff <= ST_WAIT;
               end else if (in_frame) begin
                  state_ff <= ST_WAIT;
               end else begin
                  state_ff <= ST_MOD;
               end
            end
            ST_WAIT: begin
               state_ff <= act_ff ? ST_DIV : ST_MOD;
            end
            ST_MOD: begin
               if (ox_ff == s_ff - 1'b1) begin
                  ox_ff <= '0;
                  if (oy_ff == s_ff - 1'b1) state_ff <= ST_IDLE;
                  else begin
                     oy_ff <= oy_ff + 1'b1;
                     state_ff <= ST_RD;
                  end
               end else begin
                  ox_ff <= ox_ff + 1'b1;
                  state_ff <= ST_RD;
               end
            end
            ST_DIV: begin
               if (wl_rd_ff[SW+LW-1:LW] == '0) begin
                  state_ff <= ST_OUT;
               end else if (!div_ctrl.busy) begin
                  state_ff <= ST_DIVWAIT;
               end
            end
            ST_DIVWAIT: begin
               if (div_done) state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  if (wl_rd_ff[SW+LW-1:LW] == '0) begin
                     or_ff <= '0; og_ff <= '0; ob_ff <= '0; ov_ff <= 1'b0;
                  end else begin
                     or_ff <= qr; og_ff <= qg; ob_ff <= qb; ov_ff <= 1'b1;
                  end
                  rsp_valid_ff <= 1'b1;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // Quotients stay in the divider registers until the output register is free.
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_red   = or_ff;
   assign rsp_pixel_green = og_ff;
   assign rsp_pixel_blue  = ob_ff;
   assign rsp_pixel_valid = ov_ff;
endmodule

// ===== rtl/pab_checker.sv =====
// Checker: port-level properties of the accumulation buffer, bound to the top level.
module pab_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic req_action,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_pixel_valid,
   input logic [23:0] rsp_pixel_red
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_pixel_red)) else $error("result changed");
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_pixel_valid |-> rsp_pixel_red == 24'd0) else $error("invalid nonzero");
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid) else $error("result after reset");
   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_action == pab_pkg::ACT_READ) |=> !req_ready)
      else $error("took two items");
endmodule

bind progressive_accumulation_buffer_unit pab_checker u_pab_checker (
   .clock (clock), .reset (reset), .req_valid (req_valid), .req_ready (req_ready),
   .req_action (req_action), .rsp_valid (rsp_valid), .rsp_ready (rsp_ready),
   .rsp_pixel_valid (rsp_pixel_valid), .rsp_pixel_red (rsp_pixel_red)
);
